/* sv/touch_report_decoder_macros.svh */
`ifndef TOUCH_REPORT_DECODER_MACROS_SVH
`define TOUCH_REPORT_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define TRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch report decoder check failed");

// Next-cycle implication, sampled on clk, off during rst
`define TRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch report decoder check failed");

`endif

/* sv/trd_pkg.sv */
`default_nettype none

package trd_pkg;

  localparam int unsigned MAX_SLOTS = 10;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_FAIL   = 2'd2;

  localparam logic [1:0] BK_NONE       = 2'd0;
  localparam logic [1:0] BK_INTEGRATED = 2'd1;
  localparam logic [1:0] BK_STANDALONE = 2'd2;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_270  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BACKEND        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NATIVE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NATIVE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT  = 3'd6;

  localparam logic [14:0] NATIVE_WIDTH_RST   = 15'd720;
  localparam logic [15:0] NATIVE_HEIGHT_RST  = 16'd1280;
  localparam logic [15:0] LOGICAL_WIDTH_RST  = 16'd720;
  localparam logic [15:0] LOGICAL_HEIGHT_RST = 16'd1280;
  localparam logic [7:0]  FAILURE_LIMIT_RST  = 8'd10;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] status_byte;
    logic [7:0] slot_total;
    logic [7:0] rec_byte_a;
    logic [7:0] rec_byte_b;
    logic [7:0] rec_byte_c;
    logic [7:0] rec_byte_d;
    logic       last_record;
  } trd_in_t;

  typedef struct packed {
    logic        touch_down;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        clear_request;
    logic        touch_off;
  } trd_out_t;

endpackage

`default_nettype wire

/* sv/trd_in_if.sv */
`default_nettype none

interface trd_in_if;
  logic            valid;
  logic            ready;
  trd_pkg::trd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/trd_out_if.sv */
`default_nettype none

interface trd_out_if;
  logic             valid;
  logic             ready;
  trd_pkg::trd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/touch_report_decoder.sv */
// An item is held in the input register; its result is registered in the result register.
// Throughput: 1 item per cycle unless the output stalls; input register and result
// register form the pipeline. Items that give no result still pass the input register.
// Reset (rst, synchronous, active high): empty pipeline, poll and error state cleared,
// configuration registers at their documented defaults.
`default_nettype none
`include "touch_report_decoder_macros.svh"

module touch_report_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  trd_in_if.sink                              in_ch,
  trd_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [trd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trd_pkg::CFG_W-1:0]      cfg_data
);

  logic [1:0]  backend_kind;
  logic [1:0]  rotation_mode;
  logic [14:0] native_width;
  logic [15:0] native_height;
  logic [15:0] logical_width;
  logic [15:0] logical_height;
  logic [7:0]  failure_limit;

  logic                      collecting, collecting_next;
  logic                      contact_found, contact_found_next;
  logic [15:0]               held_x, held_x_next;
  logic [15:0]               held_y, held_y_next;
  logic [trd_pkg::SLOT_W-1:0] slot_index, slot_index_next;
  logic [7:0]                error_run, error_run_next;
  logic                      latched_off, latched_off_next;

  logic              stage_valid;
  trd_pkg::trd_in_t  stage_item;
  logic              out_valid;
  trd_pkg::trd_out_t out_data;

  logic              advance;
  logic              fire;
  logic              emit;
  trd_pkg::trd_out_t res;

  logic        active;
  logic        known_action;
  logic [7:0]  err_inc;
  logic [15:0] map_nx, map_ny;
  logic [14:0] nw_top;
  logic [15:0] nh_top, lw_top, lh_top;
  logic [15:0] cx, cy;
  logic [15:0] map_x, map_y;

  assign advance      = !out_valid || out_ch.ready;
  assign in_ch.ready  = !stage_valid || advance;
  assign fire         = stage_valid && advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Point mapping: clamp to native panel, rotate, clamp to logical surface
  always_comb begin
    if (backend_kind == trd_pkg::BK_INTEGRATED) begin
      map_nx = {2'b00, stage_item.rec_byte_a[5:0], stage_item.rec_byte_b};
      map_ny = {stage_item.rec_byte_c, stage_item.rec_byte_d};
    end else begin
      map_nx = {stage_item.rec_byte_b, stage_item.rec_byte_a};
      map_ny = {stage_item.rec_byte_d, stage_item.rec_byte_c};
    end
    nw_top = (native_width == 15'd0) ? 15'd0 : native_width - 15'd1;
    nh_top = (native_height == 16'd0) ? 16'd0 : native_height - 16'd1;
    lw_top = (logical_width == 16'd0) ? 16'd0 : logical_width - 16'd1;
    lh_top = (logical_height == 16'd0) ? 16'd0 : logical_height - 16'd1;
    cx = (map_nx > {1'b0, nw_top}) ? {1'b0, nw_top} : map_nx;
    cy = (map_ny > nh_top) ? nh_top : map_ny;
    case (rotation_mode)
      trd_pkg::ROT_90: begin
        map_x = (cy > lw_top) ? 16'd0 : lw_top - cy;
        map_y = (cx > lh_top) ? lh_top : cx;
      end
      trd_pkg::ROT_270: begin
        map_x = (cy > lw_top) ? lw_top : cy;
        map_y = (cx > lh_top) ? 16'd0 : lh_top - cx;
      end
      default: begin
        map_x = (cx > lw_top) ? lw_top : cx;
        map_y = (cy > lh_top) ? lh_top : cy;
      end
    endcase
  end

  always_comb begin
    collecting_next    = collecting;
    contact_found_next = contact_found;
    held_x_next        = held_x;
    held_y_next        = held_y;
    slot_index_next    = slot_index;
    error_run_next     = error_run;
    latched_off_next   = latched_off;
    emit               = 1'b0;
    res                = '0;

    active = ((backend_kind == trd_pkg::BK_INTEGRATED) ||
              (backend_kind == trd_pkg::BK_STANDALONE)) && !latched_off;
    known_action = (stage_item.action == trd_pkg::ACT_STATUS) ||
                   (stage_item.action == trd_pkg::ACT_RECORD) ||
                   (stage_item.action == trd_pkg::ACT_FAIL);
    err_inc = (error_run == 8'hFF) ? error_run : error_run + 8'd1;

    if (known_action && !active) begin
      collecting_next = 1'b0;
      if (stage_item.action != trd_pkg::ACT_RECORD) begin
        emit          = 1'b1;
        res.touch_off = 1'b1;
      end
    end else begin
      unique case (stage_item.action)
        trd_pkg::ACT_FAIL: begin
          collecting_next = 1'b0;
          error_run_next  = err_inc;
          if (err_inc >= failure_limit) begin
            latched_off_next = 1'b1;
          end
          emit          = 1'b1;
          res.touch_off = latched_off_next;
        end
        trd_pkg::ACT_STATUS: begin
          collecting_next    = 1'b0;
          contact_found_next = 1'b0;
          slot_index_next    = '0;
          held_x_next        = '0;
          held_y_next        = '0;
          if (backend_kind == trd_pkg::BK_INTEGRATED) begin
            if (!stage_item.status_byte[3] || stage_item.slot_total == 8'd0) begin
              error_run_next = '0;
              emit           = 1'b1;
            end else begin
              collecting_next = 1'b1;
            end
          end else if (!stage_item.status_byte[7]) begin
            error_run_next = '0;
            emit           = 1'b1;
          end else if (stage_item.status_byte[4] ||
                       stage_item.status_byte[3:0] == 4'd0) begin
            error_run_next    = '0;
            emit              = 1'b1;
            res.clear_request = 1'b1;
          end else begin
            collecting_next = 1'b1;
          end
        end
        trd_pkg::ACT_RECORD: begin
          if (collecting) begin
            if (backend_kind == trd_pkg::BK_INTEGRATED) begin
              if (slot_index < trd_pkg::SLOT_W'(trd_pkg::MAX_SLOTS) && !contact_found &&
                  stage_item.rec_byte_a[7]) begin
                held_x_next        = map_x;
                held_y_next        = map_y;
                contact_found_next = 1'b1;
              end
              if (slot_index != '1) begin
                slot_index_next = slot_index + 1'b1;
              end
              if (stage_item.last_record) begin
                collecting_next = 1'b0;
                error_run_next  = '0;
                emit            = 1'b1;
                res.touch_down  = contact_found_next;
                res.pos_x       = contact_found_next ? held_x_next : 16'd0;
                res.pos_y       = contact_found_next ? held_y_next : 16'd0;
              end
            end else begin
              held_x_next       = map_x;
              held_y_next       = map_y;
              collecting_next   = 1'b0;
              error_run_next    = '0;
              emit              = 1'b1;
              res.touch_down    = 1'b1;
              res.pos_x         = map_x;
              res.pos_y         = map_y;
              res.clear_request = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      out_valid      <= 1'b0;
      collecting     <= 1'b0;
      contact_found  <= 1'b0;
      held_x         <= '0;
      held_y         <= '0;
      slot_index     <= '0;
      error_run      <= '0;
      latched_off    <= 1'b0;
      backend_kind   <= trd_pkg::BK_NONE;
      rotation_mode  <= trd_pkg::ROT_NONE;
      native_width   <= trd_pkg::NATIVE_WIDTH_RST;
      native_height  <= trd_pkg::NATIVE_HEIGHT_RST;
      logical_width  <= trd_pkg::LOGICAL_WIDTH_RST;
      logical_height <= trd_pkg::LOGICAL_HEIGHT_RST;
      failure_limit  <= trd_pkg::FAILURE_LIMIT_RST;
    end else begin
      if (in_ch.ready) begin
        stage_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= stage_valid && emit;
      end
      if (fire) begin
        collecting    <= collecting_next;
        contact_found <= contact_found_next;
        held_x        <= held_x_next;
        held_y        <= held_y_next;
        slot_index    <= slot_index_next;
        error_run     <= error_run_next;
        latched_off   <= latched_off_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          trd_pkg::REG_BACKEND: begin
            backend_kind <= cfg_data[1:0];
            collecting   <= 1'b0;
            error_run    <= '0;
            latched_off  <= 1'b0;
          end
          trd_pkg::REG_ROTATION:       rotation_mode  <= cfg_data[1:0];
          trd_pkg::REG_NATIVE_WIDTH:   native_width   <= cfg_data[14:0];
          trd_pkg::REG_NATIVE_HEIGHT:  native_height  <= cfg_data[15:0];
          trd_pkg::REG_LOGICAL_WIDTH:  logical_width  <= cfg_data[15:0];
          trd_pkg::REG_LOGICAL_HEIGHT: logical_height <= cfg_data[15:0];
          trd_pkg::REG_FAILURE_LIMIT:  failure_limit  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      stage_item <= in_ch.data;
    end
    if (fire && emit) begin
      out_data <= res;
    end
  end

  `TRD_ASSERT_SAME(a_no_touch_zero_pos, out_valid && !out_data.touch_down,
    out_data.pos_x == 16'd0 && out_data.pos_y == 16'd0)
  `TRD_ASSERT_SAME(a_touch_not_off, out_valid && out_data.touch_down, !out_data.touch_off)
  `TRD_ASSERT_SAME(a_latched_has_errors, latched_off, error_run != 8'd0)
  `TRD_ASSERT_SAME(a_found_after_slot, contact_found, slot_index != '0)
  `TRD_ASSERT_NEXT(a_stage_hold, stage_valid && !advance,
    stage_valid && $stable(stage_item))

endmodule

`default_nettype wire
